// File: rtl/core/gasp_pkg.sv
// Shared types, constants and helpers for the glyph atlas shelf packer.
`timescale 1ns / 1ps

package gasp_pkg;

	localparam int MAX_SHEETS    = 16;
	localparam int SHEET_CAP     = 1024;
	localparam int GUTTER        = 4;
	localparam int GLYPHS_ACROSS = 40;
	localparam int MCW_RESET     = 16;

	localparam int DIM_W   = 11;                   // rectangle / position field width
	localparam int PEN_W   = 12;                   // stored pen width
	localparam int SLOT_W  = 4;                    // slot field width
	localparam int CFG_W   = 11;                   // glyph width register width
	localparam int SIDE_W  = $clog2(SHEET_CAP) + 1;
	localparam int SUM_W   = 14;                   // headroom for pen + row + rect sums
	localparam int TGT_W   = CFG_W + 6;            // width of glyph width * 40

	typedef enum logic {
		OP_PLACE   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_PLACED   = 2'd0,
		ST_RELEASED = 2'd1,
		ST_IGNORED  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		op_t               operation;
		logic              sheet_kind;
		logic [DIM_W-1:0]  rect_width;
		logic [DIM_W-1:0]  rect_height;
		logic [SLOT_W-1:0] release_slot;
	} req_t;

	typedef struct packed {
		logic [DIM_W-1:0]  pos_x;
		logic [DIM_W-1:0]  pos_y;
		logic [SLOT_W-1:0] sheet_index;
		logic              new_sheet;
		status_t           status;
	} rsp_t;

	// Per-kind packing state
	typedef struct packed {
		logic [PEN_W-1:0]      pen_x;
		logic [PEN_W-1:0]      pen_y;
		logic [DIM_W-1:0]      row_tallest;
		logic [SLOT_W-1:0]     active_slot;
		logic                  active_valid;
		logic [MAX_SHEETS-1:0] slot_in_use;
	} kind_state_t;

	localparam kind_state_t KIND_RESET = '{
		pen_x:        PEN_W'(GUTTER),
		pen_y:        PEN_W'(GUTTER),
		row_tallest:  '0,
		active_slot:  '0,
		active_valid: 1'b0,
		slot_in_use:  '0
	};

	// Sheet side: next power of two (at least 2) of 40 * width, capped.
	function automatic logic [SIDE_W-1:0] side_for_width(input logic [CFG_W-1:0] w);
		logic [TGT_W-1:0]  target;
		logic [SIDE_W-1:0] side;
		target = (TGT_W'(w) << 5) + (TGT_W'(w) << 3);
		side   = SIDE_W'(SHEET_CAP);
		for (int i = $clog2(SHEET_CAP) - 1; i >= 1; i--) begin
			if (target <= TGT_W'(1 << i))
				side = SIDE_W'(1 << i);
		end
		return side;
	endfunction

endpackage

// File: rtl/core/gasp_calc.sv
// Single-pass place / release evaluation for one sheet kind.
`timescale 1ns / 1ps

module gasp_calc (
	input  gasp_pkg::req_t                    req,
	input  gasp_pkg::kind_state_t             st,
	input  logic [gasp_pkg::SIDE_W-1:0]       side,
	input  logic [gasp_pkg::CFG_W-1:0]        glyph_width,
	output gasp_pkg::rsp_t                    rsp,
	output gasp_pkg::kind_state_t             st_next,
	output logic                              side_load,
	output logic [gasp_pkg::SIDE_W-1:0]       side_new
);
	import gasp_pkg::*;

	logic [SUM_W-1:0]      x, y, w, h, tall, rowh, side_e;
	logic [SUM_W-1:0]      sum_x, sum_row, x_f, y_f, t_f, sum_y, end_x;
	logic                  need0, wrap_ovf, row_ovf, wrap, need1, need2;
	logic                  found;
	logic [SLOT_W-1:0]     free_idx;

	// lowest free slot
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = MAX_SHEETS - 1; i >= 0; i--) begin
			if (!st.slot_in_use[i]) begin
				found    = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		x      = SUM_W'(st.pen_x);
		y      = SUM_W'(st.pen_y);
		w      = SUM_W'(req.rect_width);
		h      = SUM_W'(req.rect_height);
		tall   = SUM_W'(st.row_tallest);
		side_e = SUM_W'(side);
		rowh   = (tall != '0) ? tall : h;

		need0    = !st.active_valid || !st.slot_in_use[st.active_slot];
		sum_x    = x + w + SUM_W'(GUTTER);
		sum_row  = y + rowh + h + SUM_W'(2 * GUTTER);
		wrap_ovf = !need0 && (sum_x > side_e);
		row_ovf  = sum_row > side_e;
		wrap     = wrap_ovf && !row_ovf;
		need1    = need0 || (wrap_ovf && row_ovf);

		x_f   = wrap ? SUM_W'(GUTTER) : x;
		y_f   = wrap ? (y + rowh + SUM_W'(GUTTER)) : y;
		t_f   = wrap ? '0 : tall;
		sum_y = y_f + h + SUM_W'(GUTTER);
		need2 = need1 || (sum_y > side_e);

		if (need2) begin
			x_f = SUM_W'(GUTTER);
			y_f = SUM_W'(GUTTER);
			t_f = '0;
		end
		end_x = x_f + w + SUM_W'(GUTTER);

		rsp       = '{pos_x: '0, pos_y: '0, sheet_index: '0, new_sheet: 1'b0,
		              status: ST_PLACED};
		st_next   = st;
		side_load = 1'b0;
		side_new  = side_for_width(glyph_width);

		case (req.operation)
			OP_RELEASE: begin
				rsp.sheet_index = req.release_slot;
				if (32'(req.release_slot) < MAX_SHEETS &&
				    st.slot_in_use[req.release_slot]) begin
					st_next.slot_in_use[req.release_slot] = 1'b0;
					rsp.status = ST_RELEASED;
				end else begin
					rsp.status = ST_IGNORED;
				end
			end
			OP_PLACE: begin
				if (need2 && !found) begin
					rsp.status = ST_FULL;
				end else begin
					rsp.pos_x       = x_f[DIM_W-1:0];
					rsp.pos_y       = y_f[DIM_W-1:0];
					rsp.sheet_index = need2 ? free_idx : st.active_slot;
					rsp.new_sheet   = need2;
					st_next.pen_x       = end_x[PEN_W-1:0];
					st_next.pen_y       = y_f[PEN_W-1:0];
					st_next.row_tallest = (h > t_f) ? h[DIM_W-1:0] : t_f[DIM_W-1:0];
					if (need2) begin
						st_next.slot_in_use[free_idx] = 1'b1;
						st_next.active_slot           = free_idx;
						st_next.active_valid          = 1'b1;
						side_load                     = 1'b1;
					end
				end
			end
			default: rsp.status = ST_IGNORED;
		endcase
	end

endmodule

// File: rtl/core/glyph_atlas_shelf_packer_core.sv
// Top level of the glyph atlas shelf packer: request/reply pipeline and packing state.
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// req       in   req_valid/req_ready  gasp_pkg::req_t (place or release request)
// rsp       out  rsp_valid/rsp_ready  gasp_pkg::rsp_t (position, slot, status)
// cfg       in   cfg_we               cfg_wdata, widest glyph in pixels (11 bits)
//
// One request per cycle sustained while replies are taken. A request is held in the input
// register, is evaluated and lands in the reply register once that is free or being taken.
// Per-kind state updates as the request leaves the input register.
// Reset sets both kinds' pens to the gutter, clears slot pools, sheet side to zero, glyph width to 16.
// A stalled reply holds both stages; an empty input register can still take a request.

module glyph_atlas_shelf_packer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  gasp_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output gasp_pkg::rsp_t               rsp,
	input  logic                         cfg_we,
	input  logic [gasp_pkg::CFG_W-1:0]   cfg_wdata
);
	import gasp_pkg::*;

	// stage 1: accepted request
	logic              req_valid_s1;
	req_t              req_s1;
	// stage 2: reply register
	logic              rsp_valid_s2;
	rsp_t              rsp_s2;

	// packing state, one entry per sheet kind
	kind_state_t       kind_q [2];
	logic [SIDE_W-1:0] sheet_side_q;
	logic [CFG_W-1:0]  glyph_width_q;

	kind_state_t       st_next;
	rsp_t              rsp_next;
	logic              side_load;
	logic [SIDE_W-1:0] side_new;
	logic              advance;

	// stage 1 moves on whenever the reply register is free or being taken
	assign advance   = req_valid_s1 && (!rsp_valid_s2 || rsp_ready);
	assign req_ready = !req_valid_s1 || advance;
	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	gasp_calc u_calc (
		.req            (req_s1),
		.st             (kind_q[req_s1.sheet_kind]),
		.side           (sheet_side_q),
		.glyph_width    (glyph_width_q),
		.rsp            (rsp_next),
		.st_next        (st_next),
		.side_load      (side_load),
		.side_new       (side_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_s2 <= 1'b0;
		end else begin
			if (req_ready)
				req_valid_s1 <= req_valid;
			if (advance)
				rsp_valid_s2 <= 1'b1;
			else if (rsp_ready)
				rsp_valid_s2 <= 1'b0;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req;
		if (advance)
			rsp_s2 <= rsp_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q[0]     <= KIND_RESET;
			kind_q[1]     <= KIND_RESET;
			sheet_side_q  <= '0;
			glyph_width_q <= CFG_W'(MCW_RESET);
		end else begin
			if (advance) begin
				kind_q[req_s1.sheet_kind] <= st_next;
				if (side_load)
					sheet_side_q <= side_new;
			end
			if (cfg_we)
				glyph_width_q <= cfg_wdata;
		end
	end

endmodule

// File: rtl/core/gasp_checker.sv
// Port-level checker for the glyph atlas shelf packer, bound to the top level.
`timescale 1ns / 1ps

module gasp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input gasp_pkg::req_t               req,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input gasp_pkg::rsp_t               rsp,
	input logic                         cfg_we,
	input logic [gasp_pkg::CFG_W-1:0]   cfg_wdata
);
	import gasp_pkg::*;

	// stalled reply holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("reply changed while stalled");

	// a fresh reply follows a request that was taken into the input register
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("reply without a request");

	// release and full replies carry no position
	a_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_RELEASED || rsp.status == ST_IGNORED ||
		              rsp.status == ST_FULL)
		|-> rsp.pos_x == '0 && rsp.pos_y == '0 && !rsp.new_sheet)
		else $error("position on a non-placement reply");

	// a fresh sheet places at the gutter corner
	a_fresh_corner: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_PLACED && rsp.new_sheet
		|-> rsp.pos_x == DIM_W'(GUTTER) && rsp.pos_y == DIM_W'(GUTTER))
		else $error("fresh sheet not placed at gutter");

	logic unused_ok;
	assign unused_ok = cfg_we ^ (|cfg_wdata) ^ (|req);

endmodule

bind glyph_atlas_shelf_packer_core gasp_checker u_gasp_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking bench for the glyph atlas shelf packer core: directed table, then random requests.
`timescale 1ns / 1ps

module tb_top;
	import gasp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned HOLD_CYCLES  = 200;   // long reply stall, fills the pipeline
	localparam int unsigned PHASE_ITEMS  = 270;
	localparam int unsigned MAX_GAP      = 14;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned DRAIN_CYCLES = 4;     // idle margin after the last reply is taken

	typedef struct {
		req_t r;
		bit   typed;   // want is hand-written, not taken from the predictor
		rsp_t want;
	} shelf_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	// Predicted packer state: one shelf per sheet kind, side shared by both
	kind_state_t shelf [2];
	int unsigned atlas_side;
	int unsigned glyph_width_cfg;

	rsp_t        pending_replies [$];
	shelf_row_t  directed_rows [$];
	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;
	bit          tx_calm     = 1'b0;   // sender offers back to back
	bit          rx_calm     = 1'b0;   // receiver always ready
	bit          rx_hold_req = 1'b0;   // ask the receiver for one long stall

	glyph_atlas_shelf_packer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Next power of two of 40 x glyph width, at least 2, capped at the largest sheet
	function automatic int unsigned atlas_side_for(input int unsigned w);
		int unsigned target;
		int unsigned p;
		target = w * GLYPHS_ACROSS;
		p = 2;
		while (p < target && p < SHEET_CAP)
			p = p << 1;
		return (p < SHEET_CAP) ? p : SHEET_CAP;
	endfunction

	// Applies one request to the predicted state and returns the reply it must give
	function automatic rsp_t pack_step(input req_t r);
		rsp_t        o;
		bit          kind;
		int unsigned x, y, w, h, tall, rowh, slot;
		bit          need_new;
		int          free_slot;
		o = '0;
		kind = r.sheet_kind;
		if (r.operation == OP_RELEASE) begin
			o.sheet_index = r.release_slot;
			if (shelf[kind].slot_in_use[r.release_slot]) begin
				shelf[kind].slot_in_use[r.release_slot] = 1'b0;
				o.status = ST_RELEASED;
			end else begin
				o.status = ST_IGNORED;
			end
			return o;
		end
		x    = 32'(shelf[kind].pen_x);
		y    = 32'(shelf[kind].pen_y);
		w    = 32'(r.rect_width);
		h    = 32'(r.rect_height);
		tall = 32'(shelf[kind].row_tallest);
		slot = 32'(shelf[kind].active_slot);
		need_new = !shelf[kind].active_valid || !shelf[kind].slot_in_use[slot];
		// width overflow: wrap to a new row, or a new sheet if the row will not fit
		if (!need_new && x + w + GUTTER > atlas_side) begin
			rowh = (tall > 0) ? tall : h;
			if (y + rowh + h + 2 * GUTTER > atlas_side) begin
				need_new = 1'b1;
			end else begin
				x    = GUTTER;
				y    = y + rowh + GUTTER;
				tall = 0;
			end
		end
		if (!need_new && y + h + GUTTER > atlas_side)
			need_new = 1'b1;
		if (need_new) begin
			free_slot = -1;
			for (int i = MAX_SHEETS - 1; i >= 0; i--)
				if (!shelf[kind].slot_in_use[i])
					free_slot = i;
			if (free_slot < 0) begin
				o.status = ST_FULL;   // nothing moves, not even the row wrap
				return o;
			end
			slot = free_slot;
			shelf[kind].slot_in_use[slot] = 1'b1;
			shelf[kind].active_slot  = SLOT_W'(slot);
			shelf[kind].active_valid = 1'b1;
			atlas_side  = atlas_side_for(glyph_width_cfg);
			x           = GUTTER;
			y           = GUTTER;
			tall        = 0;
			o.new_sheet = 1'b1;
		end
		o.pos_x       = DIM_W'(x);
		o.pos_y       = DIM_W'(y);
		o.sheet_index = SLOT_W'(slot);
		o.status      = ST_PLACED;
		shelf[kind].pen_x       = PEN_W'(x + w + GUTTER);
		shelf[kind].pen_y       = PEN_W'(y);
		shelf[kind].row_tallest = DIM_W'((h > tall) ? h : tall);
		return o;
	endfunction

	function automatic req_t place_req(input bit k, input int unsigned w, input int unsigned h);
		req_t r;
		r = '0;
		r.operation   = OP_PLACE;
		r.sheet_kind  = k;
		r.rect_width  = DIM_W'(w);
		r.rect_height = DIM_W'(h);
		return r;
	endfunction

	function automatic req_t release_req(input bit k, input int unsigned s);
		req_t r;
		r = '0;
		r.operation    = OP_RELEASE;
		r.sheet_kind   = k;
		r.release_slot = SLOT_W'(s);
		return r;
	endfunction

	function automatic rsp_t reply(input int unsigned x, y, idx, input bit fresh,
			input status_t st);
		rsp_t o;
		o.pos_x       = DIM_W'(x);
		o.pos_y       = DIM_W'(y);
		o.sheet_index = SLOT_W'(idx);
		o.new_sheet   = fresh;
		o.status      = st;
		return o;
	endfunction

	// Mostly sensible placements for the current side, with some releases to keep
	// slots cycling and a few oversized rectangles
	function automatic req_t random_request();
		req_t                  r;
		bit                    k;
		int unsigned           pick;
		int unsigned           lim;
		logic [MAX_SHEETS-1:0] used;
		k    = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			used = shelf[k].slot_in_use;
			r = release_req(k, $urandom_range(0, MAX_SHEETS - 1));
			if (used != '0 && $urandom_range(0, 3) != 0) begin
				do
					r.release_slot = SLOT_W'($urandom_range(0, MAX_SHEETS - 1));
				while (!used[r.release_slot]);
			end
			r.rect_width  = DIM_W'($urandom);
			r.rect_height = DIM_W'($urandom);
		end else if (pick < 95) begin
			lim = ((atlas_side != 0) ? atlas_side : SHEET_CAP) / 5;
			r = place_req(k, $urandom_range(0, lim), $urandom_range(0, lim));
			r.release_slot = SLOT_W'($urandom);
		end else begin
			r = place_req(k, $urandom_range(0, 2047), $urandom_range(0, 2047));
			r.release_slot = SLOT_W'($urandom);
		end
		return r;
	endfunction

	task automatic add_row(input req_t r, input bit typed, input rsp_t want);
		shelf_row_t row;
		row.r     = r;
		row.typed = typed;
		row.want  = want;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	task automatic log_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$write("%0t: %s: expected x=%0d y=%0d slot=%0d new=%b st=%0d",
				$realtime, what, want.pos_x, want.pos_y, want.sheet_index,
				want.new_sheet, want.status);
			$display(", got x=%0d y=%0d slot=%0d new=%b st=%0d",
				got.pos_x, got.pos_y, got.sheet_index, got.new_sheet, got.status);
		end
	endtask

	// Offer one request after a random gap, hold it until taken, then predict its reply
	task automatic send_request(input req_t r, input bit typed, input rsp_t want);
		int unsigned gap;
		rsp_t        predicted;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predicted = pack_step(r);
		pending_replies.insert(pending_replies.size(), typed ? want : predicted);
	endtask

	task automatic wait_idle();
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_glyph_width(input int unsigned w);
		cfg_wdata <= CFG_W'(w);
		cfg_we    <= 1'b1;
		@(posedge clk);
		glyph_width_cfg = w;
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stall before each reply, and one long hold-off on request
	initial begin : reply_sink
		int unsigned stall;
		rsp_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
		end
	end

	// Compare every accepted reply with the oldest prediction
	always @(posedge clk) begin : reply_check
		rsp_t  want;
		string bad;
		if (rsp_valid && rsp_ready) begin
			if (pending_replies.size() == 0) begin
				log_mismatch("reply with nothing pending", rsp_t'(0), rsp);
			end else begin
				want = pending_replies.pop_front();
				bad  = "";
				if (rsp.pos_x !== want.pos_x)             bad = {bad, " pos_x"};
				if (rsp.pos_y !== want.pos_y)             bad = {bad, " pos_y"};
				if (rsp.sheet_index !== want.sheet_index) bad = {bad, " sheet_index"};
				if (rsp.new_sheet !== want.new_sheet)     bad = {bad, " new_sheet"};
				if (rsp.status !== want.status)           bad = {bad, " status"};
				if (bad != "")
					log_mismatch({"wrong", bad}, want, rsp);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned phase_widths [6];
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		shelf[0]        = KIND_RESET;
		shelf[1]        = KIND_RESET;
		atlas_side      = 0;
		glyph_width_cfg = MCW_RESET;

		// Directed table; reset width 16 gives 1024-pixel sheets
		add_row(release_req(0, 0), 1, reply(0, 0, 0, 0, ST_IGNORED));        // free slot
		add_row(release_req(1, 15), 1, reply(0, 0, 15, 0, ST_IGNORED));
		add_row(place_req(0, 0, 0), 1, reply(GUTTER, GUTTER, 0, 1, ST_PLACED));
		// oversized: new sheet each time, still placed at the gutter
		add_row(place_req(0, 1024, 1024), 1, reply(GUTTER, GUTTER, 1, 1, ST_PLACED));
		add_row(place_req(0, 2047, 2047), 1, reply(GUTTER, GUTTER, 2, 1, ST_PLACED));
		add_row(release_req(0, 2), 1, reply(0, 0, 2, 0, ST_RELEASED));
		// active sheet gone: reopens in the lowest free slot
		add_row(place_req(0, 10, 10), 1, reply(GUTTER, GUTTER, 2, 1, ST_PLACED));
		add_row(release_req(0, 1), 1, reply(0, 0, 1, 0, ST_RELEASED));
		add_row(place_req(0, 10, 20), 0, rsp_t'(0));
		// zero-height row then overflow: advance uses the new rectangle's height
		add_row(place_req(1, 1000, 0), 1, reply(GUTTER, GUTTER, 0, 1, ST_PLACED));
		add_row(place_req(1, 100, 50), 1, reply(GUTTER, 58, 0, 0, ST_PLACED));
		for (int s = 1; s < MAX_SHEETS; s++)
			add_row(place_req(1, 1024, 1024), 1, reply(GUTTER, GUTTER, s, 1, ST_PLACED));
		add_row(place_req(1, 1024, 1024), 1, reply(0, 0, 0, 0, ST_FULL));
		add_row(release_req(1, 15), 1, reply(0, 0, 15, 0, ST_RELEASED));
		add_row(release_req(1, 15), 1, reply(0, 0, 15, 0, ST_IGNORED));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].want);
		req_valid <= 1'b0;

		// Random phases, each with its own glyph width; extremes first
		phase_widths = '{1, 1024, 5, 0, 2, 13};
		phase_widths[3] = $urandom_range(1, 1024);
		foreach (phase_widths[ph]) begin
			wait_idle();
			set_glyph_width(phase_widths[ph]);
			if (ph == 1) begin
				rx_hold_req = 1'b1;   // receiver stalls while requests keep coming
				tx_calm     = 1'b1;
				rx_calm     = 1'b0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 64 == 0 && !(ph == 1 && n == 0)) begin
					tx_calm = ($urandom_range(0, 3) == 0);
					rx_calm = ($urandom_range(0, 3) == 0);
				end
				send_request(random_request(), 1'b0, rsp_t'(0));
			end
			req_valid <= 1'b0;
		end

		wait_idle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
rtl/core/gasp_pkg.sv
rtl/core/gasp_calc.sv
rtl/core/glyph_atlas_shelf_packer_core.sv
rtl/core/gasp_checker.sv
tb/sv/tb_top.sv
